FILE: design/assert_macros.svh
// assertion macros shared by the smoothing filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop holds at every edge
`define SGB_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("smoothing filter assertion failed");

// prop holds in the same cycle as cond
`define SGB_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("smoothing filter assertion failed");

// prop holds in the cycle after cond
`define SGB_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("smoothing filter assertion failed");

`endif

FILE: design/sgb_pkg.sv
// types, constants and coefficient tables of the smoothing filter
`timescale 1ns / 1ps

package sgb_pkg;

    localparam int MAX_WINDOW_DEF  = 31;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SUM_GROWTH      = 11;
    localparam int COEF_BITS       = 8;
    localparam int NORM_BITS       = 9;
    localparam int MODE_BITS       = 2;
    localparam int WSIZE_BITS      = 5;
    localparam int PADDR_BITS      = 3;
    localparam int PDATA_BITS      = 32;

    localparam logic [MODE_BITS-1:0]  MODE_NONE   = 2'd0;
    localparam logic [MODE_BITS-1:0]  MODE_BOX    = 2'd1;
    localparam logic [MODE_BITS-1:0]  MODE_SG     = 2'd2;
    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 5'd5;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_WSIZE = 1'b1;

    localparam logic [WSIZE_BITS-1:0] SG5_SIZE  = 5'd5;
    localparam logic [WSIZE_BITS-1:0] SG7_SIZE  = 5'd7;
    localparam logic [WSIZE_BITS-1:0] SG11_SIZE = 5'd11;
    localparam logic [NORM_BITS-1:0]  SG5_NORM  = 9'd35;
    localparam logic [NORM_BITS-1:0]  SG7_NORM  = 9'd21;
    localparam logic [NORM_BITS-1:0]  SG11_NORM = 9'd429;

    localparam logic signed [COEF_BITS-1:0] SG5_W [5] =
        '{-8'sd3, 8'sd12, 8'sd17, 8'sd12, -8'sd3};
    localparam logic signed [COEF_BITS-1:0] SG7_W [7] =
        '{-8'sd2, 8'sd3, 8'sd6, 8'sd7, 8'sd6, 8'sd3, -8'sd2};
    localparam logic signed [COEF_BITS-1:0] SG11_W [11] =
        '{-8'sd36, 8'sd9, 8'sd44, 8'sd69, 8'sd84, 8'sd89,
          8'sd84, 8'sd69, 8'sd44, 8'sd9, -8'sd36};

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [WSIZE_BITS-1:0] wsize;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dv_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV
    } top_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } dv_state_t;

    // weight of tap k under the current mode and window size
    function automatic logic signed [COEF_BITS-1:0] coef_of(cfg_t cfg, int k);
        logic signed [COEF_BITS-1:0] c;
        c = '0;
        if (cfg.mode == MODE_BOX)
        begin
            if (k < int'(cfg.wsize))
            begin
                c = COEF_BITS'(1);
            end
        end
        else if (cfg.mode == MODE_SG)
        begin
            unique case (cfg.wsize)
                SG5_SIZE:
                begin
                    if (k < 5)
                    begin
                        c = SG5_W[k[2:0]];
                    end
                end
                SG7_SIZE:
                begin
                    if (k < 7)
                    begin
                        c = SG7_W[k[2:0]];
                    end
                end
                SG11_SIZE:
                begin
                    if (k < 11)
                    begin
                        c = SG11_W[k[3:0]];
                    end
                end
                default:
                begin
                    c = '0;
                end
            endcase
        end
        return c;
    endfunction

endpackage

FILE: design/sgb_cell.sv
// one tap cell: holds a delay line sample and adds its weighted share to the passing sum
`timescale 1ns / 1ps

module sgb_cell
    import sgb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int INDEX = 0,
    localparam int ACC_BITS = SAMPLE_BITS + SUM_GROWTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       shift,
    input  logic signed [SAMPLE_BITS-1:0] tap_in,
    output logic signed [SAMPLE_BITS-1:0] tap_out,
    input  logic signed [ACC_BITS-1:0] sum_in,
    input  logic                       sum_valid_in,
    output logic signed [ACC_BITS-1:0] sum_out,
    output logic                       sum_valid_out
);

    logic signed [SAMPLE_BITS-1:0]           tap_reg;
    logic signed [SAMPLE_BITS-1:0]           tap_next;
    logic signed [ACC_BITS-1:0]              sum_reg;
    logic signed [ACC_BITS-1:0]              sum_next;
    logic                                    valid_reg;
    logic signed [COEF_BITS-1:0]             coef;
    logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod;

    always_comb
    begin
        tap_next = shift ? tap_in : tap_reg;
        coef     = coef_of(cfg, INDEX);
        prod     = tap_reg * coef;
        sum_next = sum_in + ACC_BITS'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tap_reg   <= tap_next;
            valid_reg <= sum_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign tap_out       = tap_reg;
    assign sum_out       = sum_reg;
    assign sum_valid_out = valid_reg;

endmodule

FILE: design/sgb_div.sv
// restoring divider that rounds the weighted sum by the norm and saturates it
`timescale 1ns / 1ps

module sgb_div
    import sgb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int ACC_BITS = SAMPLE_BITS + SUM_GROWTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       take,
    input  logic signed [ACC_BITS-1:0] acc,
    input  logic [NORM_BITS-1:0]       norm,
    output dv_status_t                 status,
    output logic [SAMPLE_BITS-1:0]     y
);

    localparam int NUM_BITS = ACC_BITS + 2;
    localparam int DEN_BITS = NORM_BITS + 1;
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);
    localparam logic [NUM_BITS-1:0] Q_POS =
        NUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [NUM_BITS-1:0] Q_NEG = NUM_BITS'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] Y_MAX = SAMPLE_BITS'(Q_POS);
    localparam logic [SAMPLE_BITS-1:0] Y_MIN = SAMPLE_BITS'(Q_NEG);

    dv_state_t             state_reg;
    dv_state_t             state_next;
    logic [NUM_BITS-1:0]   num_reg;
    logic [NUM_BITS-1:0]   num_next;
    logic [DEN_BITS-1:0]   rem_reg;
    logic [DEN_BITS-1:0]   rem_next;
    logic [DEN_BITS-1:0]   den_reg;
    logic [DEN_BITS-1:0]   den_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    logic                  neg_reg;
    logic                  neg_next;

    logic [NUM_BITS-1:0]   n;
    logic [NUM_BITS-1:0]   mag;
    logic [DEN_BITS-1:0]   den2;
    logic [DEN_BITS:0]     trial;
    logic [DEN_BITS:0]     diff;
    logic                  ge;

    // floor((2*acc + norm) / (2*norm)) on the magnitude
    always_comb
    begin
        n     = (NUM_BITS'(acc) << 1) + NUM_BITS'(norm);
        den2  = {norm, 1'b0};
        mag   = n[NUM_BITS-1] ? (~n + NUM_BITS'(den2)) : n;
        trial = {rem_reg, num_reg[NUM_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (cnt_reg == CNT_BITS'(1))
                begin
                    state_next = DV_DONE;
                end
            end
            DV_DONE:
            begin
                if (take)
                begin
                    state_next = DV_IDLE;
                end
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (state_reg == DV_IDLE && start)
        begin
            num_next = mag;
            rem_next = '0;
            den_next = den2;
            cnt_next = CNT_BITS'(NUM_BITS);
            neg_next = n[NUM_BITS-1];
        end
        else if (state_reg == DV_RUN)
        begin
            num_next = {num_reg[NUM_BITS-2:0], ge};
            rem_next = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
        status.busy = (state_reg == DV_RUN);
        status.done = (state_reg == DV_DONE);
        if (neg_reg)
        begin
            y = (num_reg > Q_NEG) ? Y_MIN : -num_reg[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = (num_reg > Q_POS) ? Y_MAX : num_reg[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

endmodule

FILE: design/smoothing_filter_sg_boxcar_top.sv
// Streaming smoothing filter, boxcar mean or Savitzky-Golay of 5, 7 or 11 points, over a
// delay line of MAX_WINDOW samples; each result belongs to the sample half a window back and
// is rounded to nearest (ties up) and saturated. Mode 0, the spare mode 3 and an invalid
// window size pass the input through, the last with the error flag in m_tuser set. One input
// beat is taken, then the block takes no next beat until the result is in the output register:
// the partial sum walks the tap chain one cell per cycle, and the divider that applies the norm
// gives one quotient bit per cycle. A result that is not yet taken holds the block after the
// next sum is done. Configuration goes over the APB port at byte 0 (filter_mode) and byte 4
// (window_size); the user must do so only while no beat is in flight, not enforced here.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smoothing_filter_sg_boxcar_top
    import sgb_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // sample_out
    output logic                  m_tuser    // size_error
);

    localparam int ACC_BITS = SAMPLE_BITS + SUM_GROWTH;

    logic [MODE_BITS-1:0]          mode_reg;
    logic [WSIZE_BITS-1:0]         wsize_reg;
    cfg_t                          cfg;
    logic                          cfg_write;

    top_state_t                    state_reg;
    top_state_t                    state_next;
    logic                          start_reg;
    logic                          accept;
    logic                          div_start;
    logic                          out_load;

    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          pass_reg;
    logic                          pass_next;
    logic                          err_reg;
    logic                          err_next;
    logic [NORM_BITS-1:0]          norm_reg;
    logic [NORM_BITS-1:0]          norm_next;

    logic signed [SAMPLE_BITS-1:0] tap_c [MAX_WINDOW];
    logic signed [ACC_BITS-1:0]    sum_c [MAX_WINDOW+1];
    logic [MAX_WINDOW:0]           valid_c;

    dv_status_t                    dv_stat;
    logic [SAMPLE_BITS-1:0]        div_y;

    logic [SAMPLE_BITS-1:0]        out_sample_reg;
    logic                          out_err_reg;
    logic                          out_valid_reg;

    // apb registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg.mode  = mode_reg;
    assign cfg.wsize = wsize_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NONE;
            wsize_reg <= WSIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MODE:  mode_reg  <= pwdata[MODE_BITS-1:0];
                REG_WSIZE: wsize_reg <= pwdata[WSIZE_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE:  prdata = PDATA_BITS'(mode_reg);
            REG_WSIZE: prdata = PDATA_BITS'(wsize_reg);
        endcase
    end

    // size check and norm for the beat being taken
    always_comb
    begin
        pass_next = 1'b1;
        err_next  = 1'b0;
        norm_next = NORM_BITS'(1);
        unique case (mode_reg)
            MODE_BOX:
            begin
                if (wsize_reg[0] && int'(wsize_reg) <= MAX_WINDOW)
                begin
                    pass_next = 1'b0;
                    norm_next = NORM_BITS'(wsize_reg);
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            MODE_SG:
            begin
                unique case (wsize_reg)
                    SG5_SIZE:
                    begin
                        pass_next = 1'b0;
                        norm_next = SG5_NORM;
                    end
                    SG7_SIZE:
                    begin
                        pass_next = 1'b0;
                        norm_next = SG7_NORM;
                    end
                    SG11_SIZE:
                    begin
                        pass_next = 1'b0;
                        norm_next = SG11_NORM;
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                pass_next = 1'b1;
            end
        endcase
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (valid_c[MAX_WINDOW])
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        accept    = s_tvalid && s_tready;
        div_start = (state_reg == ST_SUM) && valid_c[MAX_WINDOW];
        out_load  = (state_reg == ST_DIV) && dv_stat.done && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sample;
            pass_reg <= pass_next;
            err_reg  <= err_next;
            norm_reg <= norm_next;
        end
        if (out_load)
        begin
            out_sample_reg <= pass_reg ? x_reg : div_y;
            out_err_reg    <= err_reg;
        end
    end

    // tap chain
    assign sample     = s_tdata[SAMPLE_BITS-1:0];
    assign tap_c[0]   = sample;
    assign sum_c[0]   = '0;
    assign valid_c[0] = start_reg;

    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        if (k < MAX_WINDOW - 1)
        begin : g_mid
            sgb_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .INDEX       (k)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .cfg           (cfg),
                .shift         (accept),
                .tap_in        (tap_c[k]),
                .tap_out       (tap_c[k+1]),
                .sum_in        (sum_c[k]),
                .sum_valid_in  (valid_c[k]),
                .sum_out       (sum_c[k+1]),
                .sum_valid_out (valid_c[k+1])
            );
        end
        else
        begin : g_last
            sgb_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .INDEX       (k)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .cfg           (cfg),
                .shift         (accept),
                .tap_in        (tap_c[k]),
                .tap_out       (),
                .sum_in        (sum_c[k]),
                .sum_valid_in  (valid_c[k]),
                .sum_out       (sum_c[k+1]),
                .sum_valid_out (valid_c[k+1])
            );
        end
    end

    sgb_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .take   (out_load),
        .acc    (sum_c[MAX_WINDOW]),
        .norm   (norm_reg),
        .status (dv_stat),
        .y      (div_y)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'(out_sample_reg);
    assign m_tuser  = out_err_reg;

    `SGB_ASSERT_ALWAYS(a_single_token, $onehot0(valid_c))
    `SGB_ASSERT_IMPL(a_idle_quiet, s_tready, !(|valid_c) && !dv_stat.busy && !dv_stat.done)
    `SGB_ASSERT_IMPL(a_start_free, div_start, !dv_stat.busy && !dv_stat.done)
    `SGB_ASSERT_NEXT(a_load_shown, out_load, m_tvalid)

endmodule
